### hdl/sleb_pkg.sv
// Shared types, constants, colour tables and the sine table for the status LED breathing driver.
package sleb_pkg;

	// Table and phase sizing
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 16;
	localparam int SINE_DEPTH      = 1 << SINE_TABLE_BITS;
	localparam int SINE_QUARTER    = SINE_DEPTH / 4;
	localparam int SINE_W          = 13;
	localparam int SINE_HALF       = 2048;

	// Breathing arithmetic in Q1.12
	localparam int                NUM_W       = 20;
	localparam int                FACTOR_W    = 13;
	localparam int                RECIP_SHIFT = 27;
	localparam logic [20:0]       RECIP_MUL   = 21'd1342178;
	localparam logic [SINE_W-1:0] SINE_ONE    = 13'd4096;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = 13'd4096;
	localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

	// Item kinds
	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_FLOOR_PCT  = 2'd0;
	localparam logic [1:0] REG_PEAK_PCT   = 2'd1;
	localparam logic [1:0] REG_PHASE_STEP = 2'd2;

	// Connection state codes
	localparam logic [2:0] CODE_WIFI_OFF     = 3'd0;
	localparam logic [2:0] CODE_WIFI_JOINING = 3'd1;
	localparam logic [2:0] CODE_WIFI_UP      = 3'd2;
	localparam logic [2:0] CODE_WS_JOINING   = 3'd3;
	localparam logic [2:0] CODE_WS_UP        = 3'd4;
	localparam logic [2:0] CODE_WS_REJOINING = 3'd5;

	localparam logic [23:0] COLOUR_RED    = 24'hFF0000;
	localparam logic [23:0] COLOUR_BLUE   = 24'h0000FF;
	localparam logic [23:0] COLOUR_GREEN  = 24'h00FF00;
	localparam logic [23:0] COLOUR_YELLOW = 24'hFFC800;
	localparam logic [23:0] COLOUR_ORANGE = 24'hFF6400;

	typedef logic [SINE_W-1:0] sine_t;
	typedef sine_t sine_tab_t [SINE_DEPTH];

	// Per-state context word
	typedef struct packed {
		logic [2:0]            code;
		logic                  breathe;
		logic [23:0]           colour;
		logic [PHASE_BITS-1:0] phase;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		code:    CODE_WIFI_OFF,
		breathe: 1'b0,
		colour:  COLOUR_RED,
		phase:   '0
	};

	typedef struct packed {
		logic en;
		ctx_t data;
	} ctx_wr_t;

	typedef struct packed {
		logic        valid;
		logic        bypass;
		logic [23:0] colour;
	} scale_req_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} scale_rsp_t;

	// Base colour of each connection state; unknown codes show red
	function automatic logic [23:0] colour_of(input logic [2:0] code);
		logic [23:0] c;
		case (code)
			CODE_WIFI_OFF:     c = COLOUR_RED;
			CODE_WIFI_JOINING: c = COLOUR_BLUE;
			CODE_WIFI_UP:      c = COLOUR_BLUE;
			CODE_WS_JOINING:   c = COLOUR_YELLOW;
			CODE_WS_UP:        c = COLOUR_GREEN;
			CODE_WS_REJOINING: c = COLOUR_ORANGE;
			default:           c = COLOUR_RED;
		endcase
		return c;
	endfunction

	// Joining and rejoining states breathe; the rest are solid
	function automatic logic breathes(input logic [2:0] code);
		logic b;
		case (code)
			CODE_WIFI_JOINING,
			CODE_WS_JOINING,
			CODE_WS_REJOINING: b = 1'b1;
			default:           b = 1'b0;
		endcase
		return b;
	endfunction

	// round(2048 * sin(j/quarter * pi/2)) by a Q30 Taylor series to x^13
	function automatic logic [63:0] quarter_sine(input logic [63:0] j);
		logic [63:0] x;
		logic [63:0] mag;
		logic [63:0] sum;
		x   = (j * HALF_PI_Q30) / SINE_QUARTER;
		mag = x;
		sum = x;
		for (int k = 1; k <= 6; k++) begin
			mag = (mag * x) >> 30;
			mag = (mag * x) >> 30;
			case (k)
				1:       mag = mag / 6;
				2:       mag = mag / 20;
				3:       mag = mag / 42;
				4:       mag = mag / 72;
				5:       mag = mag / 110;
				default: mag = mag / 156;
			endcase
			if (k[0]) begin
				sum = sum - mag;
			end else begin
				sum = sum + mag;
			end
		end
		return (sum * 64'd2048 + (64'd1 << 29)) >> 30;
	endfunction

	// Full-wave table of (sin+1)/2 in Q1.12, built from the quarter wave
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] v;
		int          quad;
		int          r;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			quad = i / SINE_QUARTER;
			r    = i % SINE_QUARTER;
			v    = quad[0] ? quarter_sine(64'(SINE_QUARTER - r)) : quarter_sine(64'(r));
			if (v > 64'(SINE_HALF)) begin
				v = 64'(SINE_HALF);
			end
			if (quad >= 2) begin
				tab[i] = SINE_W'(64'(SINE_HALF) - v);
			end else begin
				tab[i] = SINE_W'(64'(SINE_HALF) + v);
			end
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

### hdl/sleb_sine_rom.sv
// Synchronous sine ROM with a registered read.
module sleb_sine_rom
	import sleb_pkg::*;
(
	input  logic                       clk,
	input  logic [SINE_TABLE_BITS-1:0] addr,
	output sine_t                      data
);

	sine_t data_q;

	// Register the table entry
	always_ff @(posedge clk) begin
		data_q <= SINE_TAB[addr];
	end

	assign data = data_q;

endmodule

### hdl/sleb_ctx_ram.sv
// One-entry context store with registered read and reset value until first write.
module sleb_ctx_ram
	import sleb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  ctx_wr_t wr,
	output ctx_t    rd
);

	ctx_t mem_q;
	ctx_t rd_q;
	logic valid_q;

	// Mark the entry written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en) begin
			valid_q <= 1'b1;
		end
	end

	// Write the entry and register the read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q <= wr.data;
		end
		rd_q <= valid_q ? mem_q : CTX_RESET;
	end

	assign rd = rd_q;

endmodule

### hdl/sleb_scale.sv
// Three-stage colour scaling pipeline: breathing factor, divide by 100, channel scale.
module sleb_scale
	import sleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  scale_req_t req,
	input  sine_t      sine,
	input  logic [6:0] floor_pct,
	input  logic [6:0] peak_pct,
	output scale_rsp_t rsp
);

	logic              v_s1, v_s2, v_s3;
	logic              bypass_s1;
	logic [23:0]       colour_s1, colour_s2;
	logic [NUM_W-1:0]  pmin_s1, pmax_s1;
	logic [FACTOR_W-1:0] factor_s2;
	logic [7:0]        red_s3, green_s3, blue_s3;

	logic [NUM_W-1:0]    num;
	logic [NUM_W+20:0]   quot_prod;
	logic [FACTOR_W-1:0] factor;

	// Divide the weighted sum by 100 through a reciprocal multiply
	assign num       = pmin_s1 + pmax_s1;
	assign quot_prod = (NUM_W + 21)'(num) * (NUM_W + 21)'(RECIP_MUL);
	assign factor    = bypass_s1 ? FACTOR_ONE : quot_prod[RECIP_SHIFT +: FACTOR_W];

	// Scale one channel and saturate
	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [FACTOR_W-1:0] f);
		logic [FACTOR_W+7:0] p;
		p = (FACTOR_W + 8)'(c) * (FACTOR_W + 8)'(f);
		return (p[FACTOR_W+7:20] != '0 || p[19:12] == 8'hFF) ?
			(p[FACTOR_W+7:20] != '0 ? 8'hFF : p[19:12]) : p[19:12];
	endfunction

	// Advance the stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		bypass_s1 <= req.bypass;
		colour_s1 <= req.colour;
		pmin_s1   <= NUM_W'(floor_pct) * NUM_W'(SINE_ONE - sine);
		pmax_s1   <= NUM_W'(peak_pct) * NUM_W'(sine);
		colour_s2 <= colour_s1;
		factor_s2 <= factor;
		red_s3    <= scale_ch(colour_s2[23:16], factor_s2);
		green_s3  <= scale_ch(colour_s2[15:8], factor_s2);
		blue_s3   <= scale_ch(colour_s2[7:0], factor_s2);
	end

	assign rsp = '{valid: v_s3, red: red_s3, green: green_s3, blue: blue_s3};

endmodule

### hdl/status_led_breathing.sv
// Status LED breathing driver: 1 ms tick items and set-state items in, RGB levels out.
// An item is taken only in the idle state, so a new item waits until the last is through;
// the controller reads and writes back the context word, then, for an item with a result,
// runs the shared scale pipeline and holds the result until the output is free.
// Reset clears the controller and marks the context store unwritten, so it reads as
// wifi off, solid red, phase zero; registers reset to 30, 100 and 33.
module status_led_breathing
	import sleb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] state_code
	input  logic [0:0]  s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_LOAD,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic        kind_q;
	logic [2:0]  code_q;
	logic [6:0]  floor_pct_q;
	logic [6:0]  peak_pct_q;
	logic [15:0] phase_step_q;
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic [23:0] res_q;
	scale_req_t  req_q;

	ctx_t       ctx_rd;
	ctx_wr_t    ctx_wr;
	sine_t      sine;
	scale_rsp_t rsp;

	logic [PHASE_BITS-1:0] next_phase;
	logic                  same_code;

	// Context store, sine ROM and scaling pipeline
	sleb_ctx_ram u_ctx (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ctx_wr),
		.rd     (ctx_rd)
	);

	sleb_sine_rom u_rom (
		.clk  (clk),
		.addr (next_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
		.data (sine)
	);

	sleb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_q),
		.sine      (sine),
		.floor_pct (floor_pct_q),
		.peak_pct  (peak_pct_q),
		.rsp       (rsp)
	);

	// Modify the context read for this item
	assign next_phase = ctx_rd.phase + PHASE_BITS'(phase_step_q);
	assign same_code  = (code_q == ctx_rd.code);

	always_comb begin
		ctx_wr = '{en: 1'b0, data: ctx_rd};
		if (state_q == ST_CALC) begin
			if (kind_q == KIND_SET) begin
				ctx_wr.en           = !same_code;
				ctx_wr.data.code    = code_q;
				ctx_wr.data.breathe = breathes(code_q);
				ctx_wr.data.colour  = colour_of(code_q);
				ctx_wr.data.phase   = '0;
			end else begin
				ctx_wr.en         = 1'b1;
				ctx_wr.data.phase = next_phase;
			end
		end
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_pct_q  <= 7'd30;
			peak_pct_q   <= 7'd100;
			phase_step_q <= 16'd33;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_FLOOR_PCT:  floor_pct_q  <= cfg_data[6:0];
				REG_PEAK_PCT:   peak_pct_q   <= cfg_data[6:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_SET;
			code_q       <= CODE_WIFI_OFF;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			res_q        <= '0;
			req_q        <= '0;
		end else begin
			// Drop the output item once taken; the emit step reloads it itself
			if (m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tuser[0];
						code_q  <= s_tdata[2:0];
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (kind_q == KIND_SET) begin
						if (same_code || breathes(code_q)) begin
							state_q <= ST_IDLE;
						end else begin
							req_q   <= '{valid: 1'b1, bypass: 1'b1, colour: colour_of(code_q)};
							state_q <= ST_LOAD;
						end
					end else if (ctx_rd.breathe) begin
						req_q   <= '{valid: 1'b1, bypass: 1'b0, colour: ctx_rd.colour};
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					req_q.valid <= 1'b0;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rsp.valid) begin
						res_q   <= {rsp.blue, rsp.green, rsp.red};
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The scale pipeline answers only while the sequencer waits for it
	a_rsp_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> state_q == ST_WAIT)
		else $error("scale result outside wait state");

	// The context word is written back only in the modify step
	a_ctx_wr_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_wr.en |-> state_q == ST_CALC)
		else $error("context write outside modify step");

	// A request to the scale pipeline follows the modify step
	a_req_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		req_q.valid |-> state_q == ST_LOAD && $past(state_q) == ST_CALC)
		else $error("scale request without modify step");

endmodule
